// File: hdl/dsvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvm_pkg
// shared constants and types for the dialogue stack vm core
// ----------------------------------------------------------------------------
package dsvm_pkg;

  localparam int STACK_LIMIT  = 128;
  localparam int STACK_DEPTH  = STACK_LIMIT + 1;
  localparam int SP_W         = $clog2(STACK_DEPTH + 1);
  localparam int SA_W         = $clog2(STACK_DEPTH);
  localparam int CODE_BYTES   = 65536;
  localparam int CA_W         = $clog2(CODE_BYTES);
  localparam int VAR_COUNT    = 256;
  localparam int VA_W         = $clog2(VAR_COUNT);
  localparam logic [31:0] EXIT_ADDRESS = 32'hFFFF_FFFF;

  localparam logic [3:0] OPN_CODE_WR = 4'd0;
  localparam logic [3:0] OPN_VAR_WR  = 4'd1;
  localparam logic [3:0] OPN_VAR_RD  = 4'd2;
  localparam logic [3:0] OPN_PUSH    = 4'd3;
  localparam logic [3:0] OPN_POP     = 4'd4;
  localparam logic [3:0] OPN_TOP     = 4'd5;
  localparam logic [3:0] OPN_ENTRY   = 4'd6;
  localparam logic [3:0] OPN_BEGIN   = 4'd7;
  localparam logic [3:0] OPN_STEP    = 4'd8;

  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_EXIT  = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_LINE  = 3'd3;
  localparam logic [2:0] ST_EVENT = 3'd4;
  localparam logic [2:0] ST_ABORT = 3'd5;

  localparam logic [7:0] OP_EOF  = 8'd0;
  localparam logic [7:0] OP_PUSH = 8'd1;
  localparam logic [7:0] OP_POP  = 8'd2;
  localparam logic [7:0] OP_DUP  = 8'd3;
  localparam logic [7:0] OP_LOAD = 8'd4;
  localparam logic [7:0] OP_STOR = 8'd5;
  localparam logic [7:0] OP_LAND = 8'd6;
  localparam logic [7:0] OP_LOR  = 8'd7;
  localparam logic [7:0] OP_LNOT = 8'd8;
  localparam logic [7:0] OP_ADD  = 8'd9;
  localparam logic [7:0] OP_SUB  = 8'd10;
  localparam logic [7:0] OP_MUL  = 8'd11;
  localparam logic [7:0] OP_DIV  = 8'd12;
  localparam logic [7:0] OP_NEG  = 8'd13;
  localparam logic [7:0] OP_EQU  = 8'd14;
  localparam logic [7:0] OP_NEQ  = 8'd15;
  localparam logic [7:0] OP_IEQV = 8'd16;
  localparam logic [7:0] OP_IEQK = 8'd17;
  localparam logic [7:0] OP_LEQ  = 8'd18;
  localparam logic [7:0] OP_LTH  = 8'd19;
  localparam logic [7:0] OP_GEQ  = 8'd20;
  localparam logic [7:0] OP_GTH  = 8'd21;
  localparam logic [7:0] OP_JMP  = 8'd22;
  localparam logic [7:0] OP_JZ   = 8'd23;
  localparam logic [7:0] OP_JNZ  = 8'd24;
  localparam logic [7:0] OP_SWT  = 8'd25;
  localparam logic [7:0] OP_PROP = 8'd26;
  localparam logic [7:0] OP_PICK = 8'd27;
  localparam logic [7:0] OP_LINE = 8'd28;
  localparam logic [7:0] OP_EVT  = 8'd29;

  typedef struct packed {
    logic       start;
    logic [5:0] sel;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

  localparam logic [5:0] ALU_MUL = 6'd0;
  localparam logic [5:0] ALU_DIV = 6'd1;

endpackage

// File: hdl/dsvm_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvm_muldiv
// iterative 64-bit multiply (16 bits a cycle) and divide (one bit a cycle)
// ----------------------------------------------------------------------------
module dsvm_muldiv
  import dsvm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        is_div_r, is_div_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt, rem_r, rem_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [63:0] shrem;
  logic [79:0] pp;

  always_comb begin
    busy_nxt = busy_r; is_div_nxt = is_div_r; cnt_nxt = cnt_r;
    a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r; rem_nxt = rem_r;
    done_nxt = 1'b0;
    shrem = {rem_r[62:0], a_r[63]};
    trial = {1'b0, shrem} - {1'b0, b_r};
    pp = {16'd0, a_r} * {64'd0, b_r[15:0]};
    if (req.start) begin
      busy_nxt = 1'b1; is_div_nxt = (req.sel == ALU_DIV);
      a_nxt = req.a; b_nxt = req.b; acc_nxt = '0; rem_nxt = '0;
      cnt_nxt = (req.sel == ALU_DIV) ? 7'd64 : 7'd4;
    end else if (busy_r) begin
      if (is_div_r) begin
        if (!trial[64]) begin
          rem_nxt = trial[63:0]; acc_nxt = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = shrem; acc_nxt = {acc_r[62:0], 1'b0};
        end
        a_nxt = {a_r[62:0], 1'b0};
      end else begin
        acc_nxt = acc_r + pp[63:0];
        a_nxt = {a_r[47:0], 16'd0};
        b_nxt = {16'd0, b_r[63:16]};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    is_div_r <= is_div_nxt; cnt_r <= cnt_nxt;
    a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt; rem_r <= rem_nxt;
  end

  // divisor zero falls out of restoring division as all ones
  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

// File: hdl/dialogue_stack_vm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dialogue_stack_vm_core
// stack-machine interpreter for dialogue bytecode with code, variable and
// stack memories
// ----------------------------------------------------------------------------
// One transaction in, one result out. A step fetches its instruction one byte
// at a time, S_FETCH then S_DEC, from the single-port code memory (opcode plus
// up to 8 immediate bytes, switch reads 4 table bytes), reads each operand from
// the stack memory with an issue pass and a capture pass in S_SRD, and writes
// back one a cycle; mul and div wait in S_ALU for the iterative unit.
// After reset the variable memory is cleared in S_CLR, during which no
// input is taken.
module dialogue_stack_vm_core
  import dsvm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[3:0], address[35:4], var_key[43:36], data[107:44], zero pad
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], read_value[66:3], prop_valid[67], prop_text_offset[99:68],
  // prop_choice[107:100], reg_a[139:108], reg_b[171:140], zero pad
  output logic [175:0] out_tdata
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HOST, S_FETCH, S_DEC, S_SRD, S_VRD, S_EXE, S_ALU, S_WB,
    S_OUT
  } state_t;

  state_t state_r;

  logic [7:0]  code_mem [CODE_BYTES];
  logic [63:0] var_mem  [VAR_COUNT];
  logic [63:0] stk_mem  [STACK_DEPTH];

  logic [7:0]  code_q;
  logic [63:0] var_q, stk_q;

  logic [CA_W-1:0] code_a;
  logic            code_we;
  logic [VA_W-1:0] var_a;
  logic            var_we;
  logic [63:0]     var_wd;
  logic [SA_W-1:0] stk_a;
  logic            stk_we;
  logic [63:0]     stk_wd;

  logic [3:0]  opn_r;
  logic [31:0] addr_r;
  logic [7:0]  key_r;
  logic [63:0] data_r;

  logic [31:0] pc_r, line_r, aux_r;
  logic [7:0]  pcnt_r;
  logic [SP_W-1:0] sp_r;
  logic [7:0]  op_r;
  logic [3:0]  fcnt_r, flen_r;
  logic [31:0] fa_r;
  logic [63:0] imm_r, tbl_r;
  logic [1:0]  ocnt_r;
  logic [63:0] l_r, r_r;
  logic        swt_r, rd_pend_r;
  logic [1:0]  npop_r, npush_r;
  logic [1:0]  wcnt_r;
  logic [63:0] w0_r, w1_r;
  logic [VA_W-1:0] clr_r;

  logic [2:0]  o_st_r;
  logic [63:0] o_rv_r;
  logic        o_pv_r;
  logic [31:0] o_pt_r;
  logic [7:0]  o_pc_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  dsvm_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(alu_req), .rsp(alu_rsp));

  // memories
  always_ff @(posedge clk) begin
    if (code_we) code_mem[code_a] <= data_r[7:0];
    code_q <= code_mem[code_a];
    if (var_we) var_mem[var_a] <= var_wd;
    var_q <= var_mem[var_a];
    if (stk_we) stk_mem[stk_a] <= stk_wd;
    stk_q <= stk_mem[stk_a];
  end

  logic [31:0] fetch_addr;
  assign fetch_addr = fa_r + {28'd0, fcnt_r};

  // arity decode
  logic [1:0] pops_c, push_c;
  logic [3:0] ilen_c;
  always_comb begin
    pops_c = 2'd0; push_c = 2'd0; ilen_c = 4'd0;
    case (code_q)
      OP_PUSH: begin push_c = 2'd1; ilen_c = 4'd8; end
      OP_LOAD: begin push_c = 2'd1; ilen_c = 4'd4; end
      OP_POP: pops_c = 2'd1;
      OP_STOR: begin pops_c = 2'd1; ilen_c = 4'd4; end
      OP_JZ, OP_JNZ: begin pops_c = 2'd1; ilen_c = 4'd4; end
      OP_SWT: pops_c = 2'd1;
      OP_DUP: begin pops_c = 2'd1; push_c = 2'd2; end
      OP_IEQV: begin pops_c = 2'd1; push_c = 2'd2; ilen_c = 4'd8; end
      OP_IEQK: begin pops_c = 2'd1; push_c = 2'd2; ilen_c = 4'd4; end
      OP_LNOT, OP_NEG: begin pops_c = 2'd1; push_c = 2'd1; end
      OP_LAND, OP_LOR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQU, OP_NEQ,
      OP_LEQ, OP_LTH, OP_GEQ, OP_GTH: begin pops_c = 2'd2; push_c = 2'd1; end
      OP_JMP, OP_EVT: ilen_c = 4'd4;
      OP_PROP: ilen_c = 4'd5;
      OP_LINE: ilen_c = 4'd8;
      default: ;
    endcase
  end

  logic [SP_W:0] after_c;
  assign after_c = {1'b0, sp_r} - {{(SP_W-1){1'b0}}, pops_c} + {{(SP_W-1){1'b0}}, push_c};

  // memory address/write select
  always_comb begin
    code_a = fetch_addr[CA_W-1:0]; code_we = 1'b0;
    var_a = key_r[VA_W-1:0]; var_we = 1'b0; var_wd = data_r;
    stk_a = SA_W'(sp_r - SP_W'(1)); stk_we = 1'b0; stk_wd = w0_r;
    case (state_r)
      S_CLR: begin var_a = clr_r; var_we = 1'b1; var_wd = '0; end
      S_HOST: begin
        code_a = addr_r[CA_W-1:0];
        code_we = (opn_r == OPN_CODE_WR);
        var_we = (opn_r == OPN_VAR_WR);
        stk_a = (opn_r == OPN_PUSH) ? SA_W'(sp_r) : SA_W'(sp_r - SP_W'(1));
        stk_we = (opn_r == OPN_PUSH) && (sp_r < SP_W'(STACK_DEPTH)) && !rd_pend_r;
        stk_wd = data_r;
      end
      S_SRD: stk_a = SA_W'(sp_r - SP_W'(1) - {{(SP_W-2){1'b0}}, ocnt_r});
      S_VRD, S_EXE: var_a = imm_r[VA_W-1:0];
      S_WB: begin
        var_a = imm_r[VA_W-1:0];
        var_we = (op_r == OP_STOR);
        var_wd = l_r;
        stk_a = SA_W'(sp_r);
        stk_we = (wcnt_r != 2'd0);
      end
      default: ;
    endcase
  end

  logic [63:0] alu_c;
  always_comb begin
    case (op_r)
      OP_LAND: alu_c = {63'd0, (l_r != 0) && (r_r != 0)};
      OP_LOR:  alu_c = {63'd0, (l_r != 0) || (r_r != 0)};
      OP_ADD:  alu_c = l_r + r_r;
      OP_SUB:  alu_c = l_r - r_r;
      OP_EQU:  alu_c = {63'd0, l_r == r_r};
      OP_NEQ:  alu_c = {63'd0, l_r != r_r};
      OP_LEQ:  alu_c = {63'd0, l_r <= r_r};
      OP_LTH:  alu_c = {63'd0, l_r < r_r};
      OP_GEQ:  alu_c = {63'd0, l_r >= r_r};
      OP_GTH:  alu_c = {63'd0, l_r > r_r};
      default: alu_c = '0;
    endcase
  end

  assign alu_req.start = (state_r == S_EXE) && ((op_r == OP_MUL) || (op_r == OP_DIV));
  assign alu_req.sel = (op_r == OP_DIV) ? ALU_DIV : ALU_MUL;
  assign alu_req.a = l_r;
  assign alu_req.b = r_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {4'd0, aux_r, line_r, o_pc_r, o_pt_r, o_pv_r, o_rv_r, o_st_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0;
      pc_r <= '0; sp_r <= '0; line_r <= '0; aux_r <= '0; pcnt_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + VA_W'(1);
          if (clr_r == VA_W'(VAR_COUNT - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          opn_r <= in_tdata[3:0]; addr_r <= in_tdata[35:4];
          key_r <= in_tdata[43:36]; data_r <= in_tdata[107:44];
          o_st_r <= ST_NONE; o_rv_r <= '0; o_pv_r <= 1'b0;
          o_pt_r <= '0; o_pc_r <= '0; rd_pend_r <= 1'b0;
          if (in_tdata[3:0] == OPN_STEP) begin
            fa_r <= pc_r; fcnt_r <= '0; state_r <= S_FETCH; swt_r <= 1'b0;
          end else state_r <= S_HOST;
        end
        S_HOST: begin
          state_r <= S_OUT;
          case (opn_r)
            OPN_VAR_RD: begin
              if (!rd_pend_r) begin rd_pend_r <= 1'b1; state_r <= S_HOST; end
              else o_rv_r <= var_q;
            end
            OPN_PUSH:
              if (sp_r >= SP_W'(STACK_DEPTH)) o_st_r <= ST_ABORT;
              else sp_r <= sp_r + SP_W'(1);
            OPN_POP, OPN_TOP:
              if (sp_r == '0) o_st_r <= ST_ABORT;
              else if (!rd_pend_r) begin rd_pend_r <= 1'b1; state_r <= S_HOST; end
              else begin
                o_rv_r <= stk_q;
                if (opn_r == OPN_POP) sp_r <= sp_r - SP_W'(1);
              end
            OPN_ENTRY: pc_r <= addr_r;
            OPN_BEGIN: pcnt_r <= '0;
            default: ;
          endcase
        end
        S_FETCH: begin
          // one byte requested this cycle, data lands next cycle
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (swt_r) begin
            tbl_r <= {code_q, tbl_r[63:8]};
            if (fcnt_r == 4'd3) begin
              pc_r <= {code_q, tbl_r[63:40]};
              if ({code_q, tbl_r[63:40]} == EXIT_ADDRESS) o_st_r <= ST_EXIT;
              else if (sp_r > SP_W'(STACK_LIMIT)) o_st_r <= ST_ABORT;
              state_r <= S_OUT;
            end else begin fcnt_r <= fcnt_r + 4'd1; state_r <= S_FETCH; end
          end else if (fcnt_r == 4'd0) begin
            op_r <= code_q; npop_r <= pops_c; npush_r <= push_c; flen_r <= ilen_c;
            imm_r <= '0;
            if ({{(SP_W-2){1'b0}}, pops_c} > sp_r ||
                after_c > (SP_W+1)'(STACK_DEPTH)) begin
              o_st_r <= ST_ABORT; state_r <= S_OUT;
            end else if (ilen_c != 4'd0) begin
              fcnt_r <= 4'd1; state_r <= S_FETCH;
            end else begin
              ocnt_r <= '0; state_r <= (pops_c != 2'd0) ? S_SRD : S_EXE;
            end
          end else begin
            imm_r <= imm_r | ({56'd0, code_q} << {fcnt_r - 4'd1, 3'b000});
            if (fcnt_r == flen_r) begin
              ocnt_r <= '0;
              state_r <= (npop_r != 2'd0) ? S_SRD :
                         (op_r == OP_LOAD) ? S_VRD : S_EXE;
            end else begin fcnt_r <= fcnt_r + 4'd1; state_r <= S_FETCH; end
          end
        end
        S_SRD: begin
          // read issued; capture on the following pass
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            if (ocnt_r == 2'd0) r_r <= stk_q; else l_r <= stk_q;
            if (ocnt_r + 2'd1 == npop_r) begin
              state_r <= (op_r == OP_IEQK) ? S_VRD : S_EXE;
            end
            ocnt_r <= ocnt_r + 2'd1;
          end else rd_pend_r <= 1'b1;
        end
        S_VRD: begin
          state_r <= S_EXE; rd_pend_r <= 1'b1;
        end
        S_EXE: begin
          rd_pend_r <= 1'b0;
          sp_r <= sp_r - {{(SP_W-2){1'b0}}, npop_r};
          state_r <= S_WB;
          wcnt_r <= npush_r;
          if (npop_r == 2'd1) l_r <= r_r;
          case (op_r)
            OP_EOF: begin pc_r <= pc_r + 32'd1; o_st_r <= ST_EXIT; state_r <= S_OUT; end
            OP_PUSH: w0_r <= imm_r;
            OP_LOAD: w0_r <= var_q;
            OP_DUP: begin w0_r <= r_r; w1_r <= r_r; end
            OP_IEQV: begin w0_r <= r_r; w1_r <= {63'd0, r_r == imm_r}; end
            OP_IEQK: begin w0_r <= r_r; w1_r <= {63'd0, r_r == var_q}; end
            OP_LNOT: w0_r <= {63'd0, r_r == 0};
            OP_NEG: w0_r <= 64'd0 - r_r;
            OP_MUL, OP_DIV: state_r <= S_ALU;
            OP_SWT: begin
              swt_r <= 1'b1; fa_r <= pc_r + 32'd1 + {r_r[29:0], 2'b00};
              fcnt_r <= '0; state_r <= S_FETCH;
            end
            default: w0_r <= alu_c;
          endcase
        end
        S_ALU: if (alu_rsp.done) begin w0_r <= alu_rsp.res; state_r <= S_WB; end
        S_WB: begin
          if (wcnt_r != 2'd0) begin
            sp_r <= sp_r + SP_W'(1);
            w0_r <= w1_r; wcnt_r <= wcnt_r - 2'd1;
          end
          if (wcnt_r <= 2'd1) begin
            state_r <= S_OUT;
            pc_r <= pc_r + 32'd1 + {28'd0, flen_r};
            case (op_r)
              OP_JMP, OP_JZ, OP_JNZ: begin
                if (op_r == OP_JMP || ((op_r == OP_JZ) == (l_r == 0))) begin
                  pc_r <= imm_r[31:0];
                  if (imm_r[31:0] == EXIT_ADDRESS) o_st_r <= ST_EXIT;
                end
              end
              OP_PROP: begin
                o_pv_r <= 1'b1; o_pt_r <= imm_r[31:0]; o_pc_r <= imm_r[39:32];
                if (pcnt_r != 8'hFF) pcnt_r <= pcnt_r + 8'd1;
              end
              OP_PICK: begin aux_r <= {24'd0, pcnt_r}; o_st_r <= ST_PICK; end
              OP_LINE: begin
                line_r <= imm_r[31:0]; aux_r <= imm_r[63:32]; o_st_r <= ST_LINE;
              end
              OP_EVT: begin aux_r <= imm_r[31:0]; o_st_r <= ST_EVENT; end
              default: ;
            endcase
            if (op_r != OP_PICK && op_r != OP_LINE && op_r != OP_EVT &&
                !((op_r == OP_JMP || ((op_r == OP_JZ || op_r == OP_JNZ) &&
                   ((op_r == OP_JZ) == (l_r == 0)))) && imm_r[31:0] == EXIT_ADDRESS) &&
                (sp_r + ((wcnt_r != 2'd0) ? SP_W'(1) : SP_W'(0))) > SP_W'(STACK_LIMIT))
              o_st_r <= ST_ABORT;
          end
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/dialogue_stack_vm_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dialogue_stack_vm_core_tb
// self-checking bench for the dialogue bytecode stack machine: host operations,
// every opcode, stack limits, proposition saturation and random programs,
// each result checked against a cycle-free predictor of the machine state
// ----------------------------------------------------------------------------
module dialogue_stack_vm_core_tb;
  import dsvm_pkg::*;

  // listed from the top bit down so the layout matches out_tdata
  typedef struct packed {
    logic [31:0] reg_b;
    logic [31:0] reg_a;
    logic [7:0]  prop_choice;
    logic [31:0] prop_text_offset;
    logic        prop_valid;
    logic [63:0] read_value;
    logic [2:0]  status;
  } vm_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [175:0] out_tdata;

  dialogue_stack_vm_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // predicted machine state
  logic [7:0]  code_mem [CODE_BYTES];
  bit          code_known [CODE_BYTES];
  logic [63:0] var_mem [VAR_COUNT];
  logic [63:0] stk [STACK_DEPTH];
  int          sp;
  logic [31:0] pc_reg;
  logic [31:0] line_reg;
  logic [31:0] aux_reg;
  logic [7:0]  prop_cnt;

  vm_result_t expected_results[$];
  int errors;
  int items_sent;
  int steps_sent;
  int results_seen;
  int status_hits [6];
  bit tx_steady;
  bit rx_steady;
  int rx_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] fetch8(input logic [31:0] a);
    return code_mem[a[CA_W-1:0]];
  endfunction

  function automatic logic [31:0] fetch32(input logic [31:0] a);
    return {fetch8(a + 3), fetch8(a + 2), fetch8(a + 1), fetch8(a)};
  endfunction

  function automatic logic [63:0] fetch64(input logic [31:0] a);
    return {fetch32(a + 4), fetch32(a)};
  endfunction

  function automatic void spush(input logic [63:0] v);
    stk[sp] = v;
    sp++;
  endfunction

  function automatic logic [63:0] spop();
    sp--;
    return stk[sp];
  endfunction

  function automatic void op_arity(input logic [7:0] op, output int pops, output int pushes);
    pops = 0;
    pushes = 0;
    case (op)
      OP_PUSH, OP_LOAD: pushes = 1;
      OP_POP, OP_STOR, OP_JZ, OP_JNZ, OP_SWT: pops = 1;
      OP_DUP, OP_IEQV, OP_IEQK: begin
        pops = 1;
        pushes = 2;
      end
      OP_LNOT, OP_NEG: begin
        pops = 1;
        pushes = 1;
      end
      OP_LAND, OP_LOR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQU, OP_NEQ,
      OP_LEQ, OP_LTH, OP_GEQ, OP_GTH: begin
        pops = 2;
        pushes = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] exec_instr(inout vm_result_t r);
    logic [7:0]  op;
    logic [31:0] p;
    logic [31:0] k;
    logic [63:0] l;
    logic [63:0] rr;
    int pops;
    int pushes;
    op = fetch8(pc_reg);
    p = pc_reg + 1;
    op_arity(op, pops, pushes);
    if (sp < pops) return ST_ABORT;
    if (sp - pops + pushes > STACK_DEPTH) return ST_ABORT;
    pc_reg = p;
    case (op)
      OP_EOF: return ST_EXIT;
      OP_PUSH: begin
        spush(fetch64(p));
        pc_reg = p + 8;
      end
      OP_POP: l = spop();
      OP_DUP: spush(stk[sp-1]);
      OP_LOAD: begin
        k = fetch32(p);
        spush(var_mem[k[VA_W-1:0]]);
        pc_reg = p + 4;
      end
      OP_STOR: begin
        k = fetch32(p);
        var_mem[k[VA_W-1:0]] = spop();
        pc_reg = p + 4;
      end
      OP_LNOT: begin
        l = spop();
        spush(64'(l == 0));
      end
      OP_NEG: begin
        l = spop();
        spush(64'd0 - l);
      end
      OP_IEQV: begin
        l = stk[sp-1];
        spush(64'(l == fetch64(p)));
        pc_reg = p + 8;
      end
      OP_IEQK: begin
        l = stk[sp-1];
        k = fetch32(p);
        spush(64'(l == var_mem[k[VA_W-1:0]]));
        pc_reg = p + 4;
      end
      OP_JMP: begin
        pc_reg = fetch32(p);
        if (pc_reg == EXIT_ADDRESS) return ST_EXIT;
      end
      OP_JZ, OP_JNZ: begin
        l = spop();
        if ((op == OP_JZ) == (l == 0)) begin
          pc_reg = fetch32(p);
          if (pc_reg == EXIT_ADDRESS) return ST_EXIT;
        end else begin
          pc_reg = p + 4;
        end
      end
      OP_SWT: begin
        l = spop();
        pc_reg = fetch32(p + l[31:0] * 32'd4);
        if (pc_reg == EXIT_ADDRESS) return ST_EXIT;
      end
      OP_PROP: begin
        r.prop_valid = 1'b1;
        r.prop_text_offset = fetch32(p);
        r.prop_choice = fetch8(p + 4);
        pc_reg = p + 5;
        if (prop_cnt != 8'hFF) prop_cnt++;
      end
      OP_PICK: begin
        aux_reg = {24'd0, prop_cnt};
        return ST_PICK;
      end
      OP_LINE: begin
        line_reg = fetch32(p);
        aux_reg = fetch32(p + 4);
        pc_reg = p + 8;
        return ST_LINE;
      end
      OP_EVT: begin
        aux_reg = fetch32(p);
        pc_reg = p + 4;
        return ST_EVENT;
      end
      default: begin
        if (pops == 2) begin
          rr = spop();
          l = spop();
          case (op)
            OP_LAND: l = 64'(l != 0 && rr != 0);
            OP_LOR:  l = 64'(l != 0 || rr != 0);
            OP_ADD:  l = l + rr;
            OP_SUB:  l = l - rr;
            OP_MUL:  l = l * rr;
            OP_DIV:  l = (rr == 0) ? '1 : l / rr;
            OP_EQU:  l = 64'(l == rr);
            OP_NEQ:  l = 64'(l != rr);
            OP_LEQ:  l = 64'(l <= rr);
            OP_LTH:  l = 64'(l < rr);
            OP_GEQ:  l = 64'(l >= rr);
            default: l = 64'(l > rr);
          endcase
          spush(l);
        end
      end
    endcase
    return (sp > STACK_LIMIT) ? ST_ABORT : ST_NONE;
  endfunction

  function automatic void vm_predict(input logic [3:0] opn, input logic [31:0] addr,
                                     input logic [7:0] key, input logic [63:0] data,
                                     output vm_result_t r);
    r = '0;
    case (opn)
      OPN_CODE_WR: begin
        code_mem[addr[CA_W-1:0]] = data[7:0];
        code_known[addr[CA_W-1:0]] = 1'b1;
      end
      OPN_VAR_WR: var_mem[key[VA_W-1:0]] = data;
      OPN_VAR_RD: r.read_value = var_mem[key[VA_W-1:0]];
      OPN_PUSH: begin
        if (sp >= STACK_DEPTH) r.status = ST_ABORT;
        else spush(data);
      end
      OPN_POP: begin
        if (sp == 0) r.status = ST_ABORT;
        else r.read_value = spop();
      end
      OPN_TOP: begin
        if (sp == 0) r.status = ST_ABORT;
        else r.read_value = stk[sp-1];
      end
      OPN_ENTRY: pc_reg = addr;
      OPN_BEGIN: prop_cnt = '0;
      OPN_STEP: r.status = exec_instr(r);
      default: ;
    endcase
    r.reg_a = line_reg;
    r.reg_b = aux_reg;
  endfunction

  // ---------------------------------------------------------------- driver
  task automatic send_item(input logic [3:0] opn, input logic [31:0] addr,
                           input logic [7:0] key, input logic [63:0] data);
    vm_result_t exp;
    int gap;
    in_tdata  <= {4'd0, data, key, addr, opn};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    vm_predict(opn, addr, key, data, exp);
    expected_results.push_back(exp);
    items_sent++;
    if (opn == OPN_STEP) steps_sent++;
    gap = 0;
    if (!tx_steady) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(8, 40);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // upper address bits are ignored by the code store, so randomize them
  task automatic put_code(input logic [31:0] a, input logic [7:0] b);
    logic [31:0] wa;
    wa = {16'($urandom), a[15:0]};
    send_item(OPN_CODE_WR, wa, 8'($urandom), {32'($urandom), 24'($urandom), b});
  endtask

  task automatic ensure_code(input logic [31:0] a);
    if (!code_known[a[CA_W-1:0]]) put_code(a, 8'($urandom));
  endtask

  function automatic int imm_len(input logic [7:0] op);
    case (op)
      OP_PUSH, OP_IEQV, OP_LINE: return 8;
      OP_PROP: return 5;
      OP_LOAD, OP_STOR, OP_IEQK, OP_JMP, OP_JZ, OP_JNZ, OP_SWT, OP_EVT: return 4;
      default: return 0;
    endcase
  endfunction

  task automatic emit_instr(inout logic [31:0] a, input logic [7:0] op, input logic [63:0] imm);
    int n;
    n = imm_len(op);
    put_code(a, op);
    for (int i = 0; i < n; i++) put_code(a + 1 + i, imm[8*i +: 8]);
    a = a + 1 + n;
  endtask

  // fill every byte the next step may fetch so no unwritten code is read
  task automatic run_step();
    logic [7:0]  op;
    logic [31:0] b;
    logic [63:0] t;
    ensure_code(pc_reg);
    op = fetch8(pc_reg);
    for (int i = 1; i <= 8; i++) ensure_code(pc_reg + i);
    if (op == OP_SWT && sp > 0) begin
      t = stk[sp-1];
      b = pc_reg + 1 + t[31:0] * 32'd4;
      for (int i = 0; i < 4; i++) ensure_code(b + i);
    end
    send_item(OPN_STEP, $urandom, 8'($urandom), {$urandom, $urandom});
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checker
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (rx_steady) begin
        out_tready <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: out_tready <= 1'b0;
          4: begin
            out_tready <= 1'b0;
            rx_hold = $urandom_range(10, 50);
          end
          default: out_tready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    vm_result_t exp;
    vm_result_t act;
    if (rst_n && out_tvalid && out_tready) begin
      act = out_tdata[171:0];
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, act);
        errors++;
      end else begin
        exp = expected_results.pop_front();
        if (act.status <= ST_ABORT) status_hits[act.status]++;
        if (act.status !== exp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp.status, act.status);
          errors++;
        end
        if (act.read_value !== exp.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, exp.read_value,
                   act.read_value);
          errors++;
        end
        if (act.prop_valid !== exp.prop_valid) begin
          $display("%0t: prop_valid expected %b actual %b", $time, exp.prop_valid,
                   act.prop_valid);
          errors++;
        end
        if (act.prop_text_offset !== exp.prop_text_offset) begin
          $display("%0t: prop_text_offset expected %h actual %h", $time,
                   exp.prop_text_offset, act.prop_text_offset);
          errors++;
        end
        if (act.prop_choice !== exp.prop_choice) begin
          $display("%0t: prop_choice expected %h actual %h", $time, exp.prop_choice,
                   act.prop_choice);
          errors++;
        end
        if (act.reg_a !== exp.reg_a) begin
          $display("%0t: reg_a expected %h actual %h", $time, exp.reg_a, act.reg_a);
          errors++;
        end
        if (act.reg_b !== exp.reg_b) begin
          $display("%0t: reg_b expected %h actual %h", $time, exp.reg_b, act.reg_b);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_host_ops();
    send_item(OPN_POP, 32'd0, 8'd0, 64'd0);
    send_item(OPN_TOP, 32'd0, 8'd0, 64'd0);
    send_item(OPN_VAR_RD, 32'd0, 8'd128, 64'd0);
    send_item(OPN_VAR_WR, 32'd0, 8'd0, '1);
    send_item(OPN_VAR_WR, '1, 8'd255, 64'hA5A5_5A5A_0F0F_F0F0);
    send_item(OPN_VAR_RD, 32'd0, 8'd0, 64'd0);
    send_item(OPN_VAR_RD, 32'd0, 8'd255, 64'd0);
    send_item(OPN_PUSH, 32'd0, 8'd0, '1);
    send_item(OPN_PUSH, 32'd0, 8'd0, 64'd0);
    send_item(OPN_TOP, 32'd0, 8'd0, 64'd0);
    send_item(OPN_POP, 32'd0, 8'd0, 64'd0);
    send_item(OPN_POP, 32'd0, 8'd0, 64'd0);
    send_item(4'd9, '1, 8'hFF, '1);
    send_item(4'd15, '1, 8'hFF, '1);
    send_item(OPN_BEGIN, 32'd0, 8'd0, 64'd0);
  endtask

  task automatic test_special_steps();
    logic [31:0] a;
    // divide by zero, then unknown opcode, then jump to the exit address
    a = 32'h0000_0100;
    emit_instr(a, OP_DIV, 64'd0);
    emit_instr(a, 8'hC8, 64'd0);
    emit_instr(a, OP_JMP, {32'd0, EXIT_ADDRESS});
    send_item(OPN_ENTRY, 32'h0000_0100, 8'd0, 64'd0);
    send_item(OPN_PUSH, 32'd0, 8'd0, 64'd5);
    send_item(OPN_PUSH, 32'd0, 8'd0, 64'd0);
    repeat (3) run_step();
    send_item(OPN_POP, 32'd0, 8'd0, 64'd0);
    // binary operation with an empty stack
    a = 32'h0000_0120;
    emit_instr(a, OP_ADD, 64'd0);
    send_item(OPN_ENTRY, 32'h0000_0120, 8'd0, 64'd0);
    run_step();
  endtask

  task automatic test_prop_saturation();
    logic [31:0] a;
    a = 32'h0000_0200;
    emit_instr(a, OP_PROP, 64'h00_89AB_CDEF);
    emit_instr(a, OP_JMP, 64'h0000_0200);
    emit_instr(a, OP_PICK, 64'd0);
    send_item(OPN_BEGIN, 32'd0, 8'd0, 64'd0);
    send_item(OPN_ENTRY, 32'h0000_0200, 8'd0, 64'd0);
    tx_steady = 1'b1;
    repeat (520) run_step();
    tx_steady = 1'b0;
    send_item(OPN_ENTRY, 32'h0000_0206 + 32'd5, 8'd0, 64'd0);
    run_step();
  endtask

  // receiver holds off while the stack is filled to its physical depth
  task automatic test_stack_full();
    logic [31:0] a;
    wait_idle();
    rx_hold = 400;
    tx_steady = 1'b1;
    while (sp < STACK_DEPTH) send_item(OPN_PUSH, 32'd0, 8'd0, rand_value());
    send_item(OPN_PUSH, 32'd0, 8'd0, 64'd7);
    tx_steady = 1'b0;
    a = 32'h0000_0300;
    emit_instr(a, OP_DUP, 64'd0);
    emit_instr(a, OP_POP, 64'd0);
    send_item(OPN_ENTRY, 32'h0000_0300, 8'd0, 64'd0);
    run_step();
    send_item(OPN_ENTRY, 32'h0000_0301, 8'd0, 64'd0);
    run_step();
    while (sp > 0) send_item(($urandom_range(0, 3) == 0) ? OPN_TOP : OPN_POP,
                             32'd0, 8'd0, 64'd0);
    // everything must drain before the sender carries on
    wait_idle();
  endtask

  function automatic logic [7:0] rand_opcode();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(30, 255));
    return 8'($urandom_range(0, 29));
  endfunction

  task automatic test_random_programs();
    logic [31:0] base;
    logic [31:0] a;
    logic [7:0]  op;
    logic [63:0] imm;
    int n;
    while (items_sent < 950) begin
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 7))
        0:       base = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        1:       base = $urandom;
        default: base = 32'h0000_1000 + 32'($urandom_range(0, 255)) * 32'd64;
      endcase
      a = base;
      n = $urandom_range(3, 10);
      for (int i = 0; i < n; i++) begin
        op = rand_opcode();
        imm = rand_value();
        if (op inside {OP_JMP, OP_JZ, OP_JNZ}) begin
          case ($urandom_range(0, 5))
            0:       imm = {32'd0, EXIT_ADDRESS};
            1:       imm = {$urandom, $urandom};
            default: imm = 64'(base + $urandom_range(0, 48));
          endcase
        end
        emit_instr(a, op, imm);
      end
      send_item(OPN_ENTRY, base, 8'($urandom), {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) send_item(OPN_BEGIN, $urandom, 8'($urandom), rand_value());
      if ($urandom_range(0, 3) == 0)
        send_item(OPN_VAR_WR, $urandom, 8'($urandom), rand_value());
      while (sp < 3) send_item(OPN_PUSH, $urandom, 8'($urandom),
                               ($urandom_range(0, 1) ? 64'($urandom_range(0, 3)) : rand_value()));
      while (sp > 100) send_item(OPN_POP, $urandom, 8'($urandom), rand_value());
      repeat (n + $urandom_range(0, 4)) run_step();
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: send_item(OPN_VAR_RD, $urandom, 8'($urandom), rand_value());
          1: send_item(OPN_TOP, $urandom, 8'($urandom), rand_value());
          2: send_item(OPN_POP, $urandom, 8'($urandom), rand_value());
          default: send_item(4'($urandom_range(9, 15)), $urandom, 8'($urandom), rand_value());
        endcase
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    #50ms;
    $display("dialogue_stack_vm_core_tb failed");
    $finish;
  end

  initial begin
    errors = 0;
    items_sent = 0;
    steps_sent = 0;
    results_seen = 0;
    rx_hold = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;
    foreach (code_known[i]) code_known[i] = 1'b0;
    foreach (var_mem[i]) var_mem[i] = '0;
    sp = 0;
    pc_reg = '0;
    line_reg = '0;
    aux_reg = '0;
    prop_cnt = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_host_ops();
    test_special_steps();
    test_prop_saturation();
    test_stack_full();
    test_random_programs();

    in_tvalid <= 1'b0;
    wait_idle();
    $display("covered %0d transactions in, %0d steps, %0d results checked", items_sent,
             steps_sent, results_seen);
    $display("status mix: none %0d exit %0d pick %0d line %0d event %0d abort %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("dialogue_stack_vm_core_tb passed");
    end else begin
      $display("dialogue_stack_vm_core_tb failed");
    end
    $finish;
  end

endmodule
